>>> hw/rtl/tfvc_pkg.sv
`timescale 1ns / 1ps

package tfvc_pkg;

  // Register indexes of the configuration port.
  typedef enum logic [2:0] {
    CFG_FOLLOW_DISTANCE  = 3'd0,
    CFG_HOLD_HEIGHT      = 3'd1,
    CFG_TAKEOFF_HEIGHT   = 3'd2,
    CFG_MAX_LINEAR_SPEED = 3'd3,
    CFG_MAX_YAW_SPEED    = 3'd4,
    CFG_CAMERA_CENTER    = 3'd5,
    CFG_HEADING_GAIN     = 3'd6,
    CFG_TIMEOUT_TICKS    = 3'd7
  } cfg_idx_t;

  // Operating modes reported with each command.
  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_CLIMB  = 3'd1,
    MODE_SEARCH = 3'd2,
    MODE_TRACK  = 3'd3,
    MODE_WAIT   = 3'd4
  } mode_t;

  // Detection message codes; the reserved code counts as no message.
  typedef enum logic [1:0] {
    MSG_NONE         = 2'd0,
    MSG_DETECTED     = 2'd1,
    MSG_NOT_DETECTED = 2'd2,
    MSG_RESERVED     = 2'd3
  } msg_t;

  localparam int CfgDataW = 24;

  typedef struct packed {
    logic [22:0] follow_distance;
    logic [22:0] hold_height;
    logic [22:0] takeoff_height;
    logic [19:0] max_linear_speed;
    logic [17:0] max_yaw_speed;
    logic [11:0] camera_center;
    logic [23:0] heading_gain;
    logic [15:0] timeout_ticks;
  } cfg_t;

  localparam logic [22:0] FollowDistanceRst = 23'd196608;
  localparam logic [22:0] HoldHeightRst     = 23'd196608;
  localparam logic [22:0] TakeoffHeightRst  = 23'd196608;
  localparam logic [19:0] MaxLinearRst      = 20'd65536;
  localparam logic [17:0] MaxYawRst         = 18'd11469;
  localparam logic [11:0] CameraCenterRst   = 12'd424;
  localparam logic [23:0] HeadingGainRst    = 24'd42950;
  localparam logic [15:0] TimeoutRst        = 16'd100;

  // Root operand, root, dividend and divisor widths of the iterative units.
  localparam int RadW  = 65;
  localparam int RootW = 33;
  localparam int NumW  = 55;
  localparam int DenW  = 33;

endpackage

>>> hw/rtl/target_follow_velocity_controller_core.sv
`timescale 1ns / 1ps

// Target-following velocity controller. One control tick enters on the input
// channel (in_valid/in_ready) with arming, pose, target and bounding-box data
// and an optional detection message; at most one velocity command leaves on
// the output channel (out_valid/out_ready). Tracking ticks that lack pose,
// target or a well-formed box produce no command.
// Configuration registers are written over the cfg channel, which is always
// ready; write them only while no tick is in flight.
// Idle, climb, search and waiting ticks go from the decide state straight
// to the output state; the input is free again once the output register
// takes the result. A tracking tick runs two squares, a 33-step square root
// and two 55-step divisions one after another through a single shared 32x32
// multiplier, the root unit and the divider. A tracking tick without data
// goes from the decide state straight back to idle. One tick is worked on
// at a time; in_ready is high only while the sequencer is idle.
// A finished result sits in the output register until transferred, and a new
// tick may be taken meanwhile; its result waits for the register to free up.
// Synchronous reset restores the register defaults, clears the at-height
// latch and the detected flag, and sets the tick counter to its saturated 65535.
module target_follow_velocity_controller_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [2:0]                    cfg_index,
  input  logic [tfvc_pkg::CfgDataW-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          armed_offboard,
  input  logic                          pose_valid,
  input  logic                          target_valid,
  input  logic [1:0]                    detect_msg,
  input  logic signed [31:0]            drone_x,
  input  logic signed [31:0]            drone_y,
  input  logic signed [31:0]            drone_z,
  input  logic signed [31:0]            target_x,
  input  logic signed [31:0]            target_y,
  input  logic                          box_valid,
  input  logic [11:0]                   box_left,
  input  logic [11:0]                   box_right,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [20:0]            vel_x,
  output logic signed [20:0]            vel_y,
  output logic signed [16:0]            vel_z,
  output logic signed [18:0]            heading_rate,
  output logic [2:0]                    mode
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_SQX, S_SQY, S_SUM, S_YAW, S_ROOT,
    S_MX, S_DX, S_WX, S_MY, S_DY, S_WY, S_OUT
  } state_t;

  localparam logic signed [16:0] HalfMps = 17'sd32768;
  localparam logic [32:0] MinDist        = 33'd66;

  tfvc_pkg::cfg_t cfg;

  // Captured tick.
  logic        r_armed, r_pose, r_tgt, r_box;
  logic [1:0]  r_msg;
  logic signed [31:0] r_px, r_py, r_pz, r_tx, r_ty;
  logic [11:0] r_left, r_right;

  // Persistent controller state.
  logic        at_height, detected;
  logic [15:0] ticks;

  state_t state;

  logic signed [32:0] dx, dy;
  logic [63:0] acc;
  logic [63:0] mul_p;
  logic [31:0] mul_a, mul_b;
  logic [32:0] dist_m;
  logic        n_neg;

  logic signed [20:0] res_vx, res_vy;
  logic signed [16:0] res_vz;
  logic signed [18:0] res_yaw;
  tfvc_pkg::mode_t    res_mode;

  logic root_start, root_busy, div_start, div_busy;
  logic [tfvc_pkg::RootW-1:0] root;
  logic [tfvc_pkg::NumW-1:0]  quot;

  tfvc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tfvc_root u_root (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand ({1'b0, acc} + {1'b0, mul_p}),
    .busy     (root_busy),
    .root     (root)
  );

  tfvc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (mul_p[tfvc_pkg::NumW-1:0]),
    .den   (dist_m),
    .busy  (div_busy),
    .quot  (quot)
  );

  assign in_ready   = (state == S_IDLE);
  assign root_start = (state == S_SUM);
  assign div_start  = (state == S_DX) || (state == S_DY);

  // Message handling and the timeout check for this tick.
  logic        det1;
  logic [15:0] tick1;
  logic        timed_out;

  always_comb begin
    if (r_msg == tfvc_pkg::MSG_DETECTED) begin
      det1  = 1'b1;
      tick1 = '0;
    end else begin
      det1  = (r_msg == tfvc_pkg::MSG_NOT_DETECTED) ? 1'b0 : detected;
      tick1 = (ticks == 16'hFFFF) ? ticks : ticks + 16'd1;
    end
    timed_out = tick1 > cfg.timeout_ticks;
  end

  // Altitude hold term: half the height error, floored, clamped to 0.5 m/s.
  logic signed [33:0] alt_err;
  logic signed [32:0] alt_half;
  logic signed [16:0] alt_term;

  always_comb begin
    alt_err  = $signed({11'b0, cfg.hold_height}) - $signed({{2{r_pz[31]}}, r_pz});
    alt_half = alt_err[33:1];
    if (alt_half > 33'sd32768) begin
      alt_term = HalfMps;
    end else if (alt_half < -33'sd32768) begin
      alt_term = -HalfMps;
    end else begin
      alt_term = alt_half[16:0];
    end
  end

  // Horizontal offsets and magnitudes; every magnitude fits in 32 bits.
  logic [32:0] ndx, ndy;
  logic [31:0] ax, ay;

  always_comb begin
    ndx = 33'(-dx);
    ndy = 33'(-dy);
    ax  = dx[32] ? ndx[31:0] : dx[31:0];
    ay  = dy[32] ? ndy[31:0] : dy[31:0];
  end

  // Pixel error of the box center, doubled.
  logic signed [13:0] num_px;
  logic [13:0]        num_neg;
  logic [12:0]        num_mag;

  always_comb begin
    num_px  = $signed({2'b0, r_left}) + $signed({2'b0, r_right})
            - $signed({1'b0, cfg.camera_center, 1'b0});
    num_neg = 14'(-num_px);
    num_mag = num_px[13] ? num_neg[12:0] : num_px[12:0];
  end

  // Shared multiplier operand selection.
  always_comb begin
    unique case (state)
      S_SQX:   begin mul_a = ax;                mul_b = ax; end
      S_SQY:   begin mul_a = ay;                mul_b = ay; end
      S_SUM:   begin mul_a = {19'b0, num_mag};  mul_b = {8'b0, cfg.heading_gain}; end
      S_MX:    begin mul_a = ax;                mul_b = {9'b0, cfg.follow_distance}; end
      S_MY:    begin mul_a = ay;                mul_b = {9'b0, cfg.follow_distance}; end
      default: begin mul_a = '0;                mul_b = '0; end
    endcase
  end

  // Yaw from the registered product: floor of the signed product over 2^17.
  logic signed [38:0] yaw_prod;
  logic signed [21:0] yaw_raw;
  logic signed [18:0] yaw_clamped;

  always_comb begin
    yaw_prod = n_neg ? 39'(-$signed({1'b0, mul_p[37:0]})) : $signed({1'b0, mul_p[37:0]});
    yaw_raw  = yaw_prod[38:17];
    if (yaw_raw > $signed({4'b0, cfg.max_yaw_speed})) begin
      yaw_clamped = $signed({1'b0, cfg.max_yaw_speed});
    end else if (yaw_raw < -$signed({4'b0, cfg.max_yaw_speed})) begin
      yaw_clamped = 19'(-$signed({1'b0, cfg.max_yaw_speed}));
    end else begin
      yaw_clamped = yaw_raw[18:0];
    end
  end

  // Distance keeping: offset minus the scaled quotient, toward zero, clamped.
  function automatic logic signed [20:0] keep(input logic signed [32:0] d,
                                              input logic [54:0] q,
                                              input logic [19:0] lim);
    logic signed [56:0] v;
    logic signed [56:0] l;
    begin
      l = $signed({37'b0, lim});
      if (d[32]) begin
        v = $signed({{24{d[32]}}, d}) + $signed({2'b0, q});
      end else begin
        v = $signed({{24{d[32]}}, d}) - $signed({2'b0, q});
      end
      if (v > l) begin
        keep = $signed({1'b0, lim});
      end else if (v < -l) begin
        keep = 21'(-$signed({1'b0, lim}));
      end else begin
        keep = v[20:0];
      end
    end
  endfunction

  always_ff @(posedge clk) begin
    mul_p <= {32'b0, mul_a} * {32'b0, mul_b};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      at_height <= 1'b0;
      detected  <= 1'b0;
      ticks     <= 16'hFFFF;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            r_armed <= armed_offboard;
            r_pose  <= pose_valid;
            r_tgt   <= target_valid;
            r_msg   <= detect_msg;
            r_px    <= drone_x;
            r_py    <= drone_y;
            r_pz    <= drone_z;
            r_tx    <= target_x;
            r_ty    <= target_y;
            r_box   <= box_valid;
            r_left  <= box_left;
            r_right <= box_right;
            state   <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          ticks    <= tick1;
          res_vx   <= '0;
          res_vy   <= '0;
          dx       <= $signed({r_tx[31], r_tx}) - $signed({r_px[31], r_px});
          dy       <= $signed({r_ty[31], r_ty}) - $signed({r_py[31], r_py});
          n_neg    <= num_px[13];
          // Tracking skips the timeout.
          detected <= det1 && (!timed_out || (r_armed && at_height));
          if (!r_armed) begin
            res_mode <= tfvc_pkg::MODE_IDLE;
            res_vz   <= '0;
            res_yaw  <= '0;
            state    <= S_OUT;
          end else if (!at_height) begin
            res_yaw <= '0;
            state   <= S_OUT;
            if (!r_pose) begin
              res_mode <= tfvc_pkg::MODE_WAIT;
              res_vz   <= '0;
            end else begin
              res_mode <= tfvc_pkg::MODE_CLIMB;
              res_vz   <= HalfMps;
              if (r_pz >= $signed({9'b0, cfg.takeoff_height})) begin
                at_height <= 1'b1;
              end
            end
          end else if (!det1) begin
            state <= S_OUT;
            if (!r_pose) begin
              res_mode <= tfvc_pkg::MODE_WAIT;
              res_vz   <= '0;
              res_yaw  <= '0;
            end else begin
              res_mode <= tfvc_pkg::MODE_SEARCH;
              res_vz   <= alt_term;
              res_yaw  <= $signed({1'b0, cfg.max_yaw_speed});
            end
          end else begin
            // With missing data the tracking tick ends silently.
            res_mode <= tfvc_pkg::MODE_TRACK;
            res_vz   <= alt_term;
            if (!r_pose || !r_tgt || !r_box || (r_left >= r_right)) begin
              state <= S_IDLE;
            end else begin
              state <= S_SQX;
            end
          end
        end
        S_SQX: state <= S_SQY;
        S_SQY: begin
          acc   <= mul_p;
          state <= S_SUM;
        end
        S_SUM: state <= S_YAW;
        S_YAW: begin
          res_yaw <= yaw_clamped;
          state   <= S_ROOT;
        end
        S_ROOT: begin
          if (!root_busy) begin
            dist_m <= (root < MinDist) ? MinDist : root;
            state  <= S_MX;
          end
        end
        S_MX: state <= S_DX;
        S_DX: state <= S_WX;
        S_WX: begin
          if (!div_busy) begin
            res_vx <= keep(dx, quot, cfg.max_linear_speed);
            state  <= S_MY;
          end
        end
        S_MY: state <= S_DY;
        S_DY: state <= S_WY;
        S_WY: begin
          if (!div_busy) begin
            res_vy <= keep(dy, quot, cfg.max_linear_speed);
            state  <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            vel_x        <= res_vx;
            vel_y        <= res_vy;
            vel_z        <= res_vz;
            heading_rate <= res_yaw;
            mode         <= res_mode;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/tfvc_cfg.sv
`timescale 1ns / 1ps

module tfvc_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [2:0]                     cfg_index,
  input  logic [tfvc_pkg::CfgDataW-1:0]  cfg_data,
  output tfvc_pkg::cfg_t                 cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.follow_distance  <= tfvc_pkg::FollowDistanceRst;
      cfg.hold_height      <= tfvc_pkg::HoldHeightRst;
      cfg.takeoff_height   <= tfvc_pkg::TakeoffHeightRst;
      cfg.max_linear_speed <= tfvc_pkg::MaxLinearRst;
      cfg.max_yaw_speed    <= tfvc_pkg::MaxYawRst;
      cfg.camera_center    <= tfvc_pkg::CameraCenterRst;
      cfg.heading_gain     <= tfvc_pkg::HeadingGainRst;
      cfg.timeout_ticks    <= tfvc_pkg::TimeoutRst;
    end else if (cfg_valid) begin
      unique case (tfvc_pkg::cfg_idx_t'(cfg_index))
        tfvc_pkg::CFG_FOLLOW_DISTANCE:  cfg.follow_distance  <= cfg_data[22:0];
        tfvc_pkg::CFG_HOLD_HEIGHT:      cfg.hold_height      <= cfg_data[22:0];
        tfvc_pkg::CFG_TAKEOFF_HEIGHT:   cfg.takeoff_height   <= cfg_data[22:0];
        tfvc_pkg::CFG_MAX_LINEAR_SPEED: cfg.max_linear_speed <= cfg_data[19:0];
        tfvc_pkg::CFG_MAX_YAW_SPEED:    cfg.max_yaw_speed    <= cfg_data[17:0];
        tfvc_pkg::CFG_CAMERA_CENTER:    cfg.camera_center    <= cfg_data[11:0];
        tfvc_pkg::CFG_HEADING_GAIN:     cfg.heading_gain     <= cfg_data[23:0];
        tfvc_pkg::CFG_TIMEOUT_TICKS:    cfg.timeout_ticks    <= cfg_data[15:0];
      endcase
    end
  end

endmodule

>>> hw/rtl/tfvc_root.sv
`timescale 1ns / 1ps

module tfvc_root (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [tfvc_pkg::RadW-1:0]     radicand,
  output logic                          busy,
  output logic [tfvc_pkg::RootW-1:0]    root
);

  // Restoring square root, one result bit per cycle.
  logic [65:0] opnd;
  logic [35:0] rem;
  logic [5:0]  cnt;
  logic [37:0] rem2;
  logic [37:0] trial;

  always_comb begin
    rem2  = {rem, opnd[65:64]};
    trial = {3'b0, root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 6'(tfvc_pkg::RootW - 1);
      opnd <= {1'b0, radicand};
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      opnd <= {opnd[63:0], 2'b00};
      if (rem2 >= trial) begin
        rem  <= 36'(rem2 - trial);
        root <= {root[tfvc_pkg::RootW-2:0], 1'b1};
      end else begin
        rem  <= rem2[35:0];
        root <= {root[tfvc_pkg::RootW-2:0], 1'b0};
      end
      if (cnt == '0) begin
        busy <= 1'b0;
      end
      cnt <= cnt - 6'd1;
    end
  end

endmodule

>>> hw/rtl/tfvc_div.sv
`timescale 1ns / 1ps

module tfvc_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [tfvc_pkg::NumW-1:0]    num,
  input  logic [tfvc_pkg::DenW-1:0]    den,
  output logic                         busy,
  output logic [tfvc_pkg::NumW-1:0]    quot
);

  // Restoring division, one quotient bit per cycle, MSB first.
  logic [tfvc_pkg::NumW-1:0] dvd;
  logic [tfvc_pkg::DenW-1:0] dvs;
  logic [tfvc_pkg::DenW-1:0] rem;
  logic [5:0]                cnt;
  logic [tfvc_pkg::DenW:0]   rem2;

  assign rem2 = {rem, dvd[tfvc_pkg::NumW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 6'(tfvc_pkg::NumW - 1);
      dvd  <= num;
      dvs  <= den;
      rem  <= '0;
      quot <= '0;
    end else if (busy) begin
      dvd <= {dvd[tfvc_pkg::NumW-2:0], 1'b0};
      if (rem2 >= {1'b0, dvs}) begin
        rem  <= tfvc_pkg::DenW'(rem2 - {1'b0, dvs});
        quot <= {quot[tfvc_pkg::NumW-2:0], 1'b1};
      end else begin
        rem  <= rem2[tfvc_pkg::DenW-1:0];
        quot <= {quot[tfvc_pkg::NumW-2:0], 1'b0};
      end
      if (cnt == '0) begin
        busy <= 1'b0;
      end
      cnt <= cnt - 6'd1;
    end
  end

endmodule
